// ===== src/lzss_stream_decompressor_unit_assert.svh =====
// Assertion macros shared by the decompressor's checking code.
`ifndef LZSS_STREAM_DECOMPRESSOR_UNIT_ASSERT_SVH
`define LZSS_STREAM_DECOMPRESSOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define LZSD_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lzsd assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define LZSD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lzsd assertion failed");

`endif

// ===== src/lzsd_pkg.sv =====
// Shared types and constants of the LZSS stream decompressor.
package lzsd_pkg;

   localparam int unsigned WinAddrW   = 12;
   localparam int unsigned WinDepth   = 4096;
   localparam int unsigned CountW     = 24;
   localparam int unsigned LenW       = 5;
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueuePtrW  = 2;

   localparam logic [3:0]      FlagsPerControl = 4'd8;
   localparam logic [LenW-1:0] MatchLenBias    = 5'd2;

   typedef enum logic [1:0] {
      PHASE_CONTROL,
      PHASE_FIRST,
      PHASE_SECOND
   } phase_type;

   // One unit of work for the copy engine: a literal or a match.
   typedef struct packed {
      logic                start;
      logic                is_match;
      logic [7:0]          lit_byte;
      logic [WinAddrW-1:0] src;
      logic [LenW-1:0]     len;
      logic                done;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== src/lzsd_front.sv =====
// Front end: parses control bytes and tokens, keeps the output count, issues copy commands.
module lzsd_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_in_byte,
   input  logic                               req_stream_start,
   input  logic [lzsd_pkg::CountW-1:0]        output_length,
   input  lzsd_pkg::queue_status_type         q_status,
   output logic                               q_push,
   output lzsd_pkg::cmd_type                  q_cmd
);
   import lzsd_pkg::*;

   phase_type            phase_ff, phase_in;
   logic [7:0]           flags_ff, flags_in;
   logic [3:0]           left_ff, left_in;
   logic [7:0]           held_ff, held_in;
   logic [CountW-1:0]    count_ff, count_in;
   logic                 pend_start_ff, pend_start_in;

   phase_type            eff_phase;
   logic [7:0]           eff_flags;
   logic [3:0]           eff_left;
   logic [7:0]           eff_held;
   logic [CountW-1:0]    eff_count;
   logic                 accept;
   logic                 active;
   logic [CountW-1:0]    remaining;
   logic [LenW-1:0]      match_len;
   logic [LenW-1:0]      match_n;
   logic [LenW-1:0]      emit_n;
   logic [CountW-1:0]    count_new;
   logic [3:0]           left_dec;
   logic                 flag;

   assign req_ready = !q_status.full;

   // A stream start clears the parse state before the byte is looked at.
   always_comb begin
      accept    = req_valid && req_ready;
      eff_phase = req_stream_start ? PHASE_CONTROL : phase_ff;
      eff_flags = req_stream_start ? 8'd0 : flags_ff;
      eff_left  = req_stream_start ? 4'd0 : left_ff;
      eff_held  = req_stream_start ? 8'd0 : held_ff;
      eff_count = req_stream_start ? '0 : count_ff;
      active    = accept && (eff_count < output_length);
      remaining = output_length - eff_count;
      match_len = {1'b0, req_in_byte[3:0]} + MatchLenBias;
      match_n   = (remaining < {{(CountW-LenW){1'b0}}, match_len}) ?
                  remaining[LenW-1:0] : match_len;
      flag      = eff_flags[0];
      left_dec  = (eff_left != 4'd0) ? eff_left - 4'd1 : 4'd0;
      unique case (eff_phase)
         PHASE_FIRST:  emit_n = flag ? 5'd1 : 5'd0;
         PHASE_SECOND: emit_n = match_n;
         default:      emit_n = 5'd0;
      endcase
      count_new = eff_count + {{(CountW-LenW){1'b0}}, emit_n};
   end

   // Next state of the token parser.
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         phase_in = eff_phase;
         if (active) begin
            unique case (eff_phase)
               PHASE_FIRST: begin
                  if (flag) begin
                     phase_in = (left_dec != 4'd0) ? PHASE_FIRST : PHASE_CONTROL;
                  end else begin
                     phase_in = PHASE_SECOND;
                  end
               end
               PHASE_SECOND: begin
                  phase_in = (left_dec != 4'd0) ? PHASE_FIRST : PHASE_CONTROL;
               end
               default: begin
                  phase_in = PHASE_FIRST;
               end
            endcase
         end
      end
   end

   // Command to the copy engine.
   always_comb begin
      q_push         = active && (emit_n != 5'd0);
      q_cmd.start    = req_stream_start || pend_start_ff;
      q_cmd.is_match = (eff_phase == PHASE_SECOND);
      q_cmd.lit_byte = req_in_byte;
      q_cmd.src      = {eff_held, req_in_byte[7:4]};
      q_cmd.len      = emit_n;
      q_cmd.done     = (count_new == output_length);
   end

   always_comb begin
      flags_in      = flags_ff;
      left_in       = left_ff;
      held_in       = held_ff;
      count_in      = count_ff;
      pend_start_in = pend_start_ff;
      if (accept) begin
         flags_in = eff_flags;
         left_in  = eff_left;
         held_in  = eff_held;
         count_in = eff_count;
         if (q_push) begin
            pend_start_in = 1'b0;
         end else if (req_stream_start) begin
            pend_start_in = 1'b1;
         end
         if (active) begin
            count_in = count_new;
            unique case (eff_phase)
               PHASE_FIRST: begin
                  if (flag) begin
                     flags_in = {1'b0, eff_flags[7:1]};
                     left_in  = left_dec;
                  end else begin
                     held_in = req_in_byte;
                  end
               end
               PHASE_SECOND: begin
                  flags_in = {1'b0, eff_flags[7:1]};
                  left_in  = left_dec;
               end
               default: begin
                  flags_in = req_in_byte;
                  left_in  = FlagsPerControl;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_CONTROL;
         flags_ff      <= 8'd0;
         left_ff       <= 4'd0;
         held_ff       <= 8'd0;
         count_ff      <= '0;
         pend_start_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         flags_ff      <= flags_in;
         left_ff       <= left_in;
         held_ff       <= held_in;
         count_ff      <= count_in;
         pend_start_ff <= pend_start_in;
      end
   end

endmodule

// ===== src/lzsd_queue.sv =====
// Short command queue between the parser and the copy engine.
module lzsd_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  lzsd_pkg::cmd_type           push_cmd,
   input  logic                        pop,
   output lzsd_pkg::cmd_type           head_cmd,
   output lzsd_pkg::queue_status_type  status
);
   import lzsd_pkg::*;

   cmd_type                slots_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueuePtrW:0]     fill_ff, fill_in;

   always_comb begin
      status.full  = (fill_ff == (QueuePtrW+1)'(QueueDepth));
      status.empty = (fill_ff == '0);
      head_cmd     = slots_ff[rd_ptr_ff];
      wr_ptr_in    = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in    = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in      = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ===== src/lzsd_back.sv =====
// Copy engine: owns the window memory and produces at most one output byte per cycle, none while rsp_ stalls.
module lzsd_back (
   input  logic                        clock,
   input  logic                        reset,
   input  lzsd_pkg::cmd_type           head_cmd,
   input  lzsd_pkg::queue_status_type  q_status,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_last_of_run,
   output logic                        rsp_stream_done
);
   import lzsd_pkg::*;

   logic [7:0]            window_mem_ff [WinDepth];
   logic [7:0]            mem_q_ff;

   // Command being worked through.
   logic                  a_busy_ff, a_busy_in;
   logic                  a_match_ff, a_match_in;
   logic [7:0]            a_byte_ff, a_byte_in;
   logic [WinAddrW-1:0]   a_src_ff, a_src_in;
   logic [LenW-1:0]       a_len_ff, a_len_in;
   logic                  a_done_ff, a_done_in;

   // Byte waiting for its window read.
   logic                  b_v_ff, b_v_in;
   logic                  b_match_ff;
   logic [7:0]            b_byte_ff;
   logic                  b_fwd_ff;
   logic                  b_hit_ff;
   logic                  b_last_ff;
   logic                  b_done_ff;

   logic [WinAddrW-1:0]   wp_ff, wp_in;
   logic [WinAddrW:0]     fill_ff, fill_in;
   logic [7:0]            last_wr_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_byte_ff;
   logic                  rsp_last_ff;
   logic                  rsp_done_ff;

   logic                  advance;
   logic                  load;
   logic                  issue;
   logic                  entry_valid;
   logic                  a_final;
   logic [7:0]            b_data;

   always_comb begin
      advance = !rsp_valid_ff || rsp_ready;
      load    = !a_busy_ff && !q_status.empty && (!head_cmd.start || !b_v_ff);
      issue   = advance && a_busy_ff;
      q_pop   = load;
      a_final = (a_len_ff == 5'd1);
      // Positions 1, 2, ... are written in order after a stream start, so the
      // fill count tells which entries hold real data; the rest read as zero.
      entry_valid = fill_ff[WinAddrW] ||
                    ((a_src_ff != '0) && (a_src_ff <= fill_ff[WinAddrW-1:0]));
      if (b_match_ff) begin
         if (b_fwd_ff) begin
            b_data = last_wr_ff;
         end else if (b_hit_ff) begin
            b_data = mem_q_ff;
         end else begin
            b_data = 8'd0;
         end
      end else begin
         b_data = b_byte_ff;
      end
   end

   always_comb begin
      a_busy_in  = a_busy_ff;
      a_match_in = a_match_ff;
      a_byte_in  = a_byte_ff;
      a_src_in   = a_src_ff;
      a_len_in   = a_len_ff;
      a_done_in  = a_done_ff;
      if (load) begin
         a_busy_in  = 1'b1;
         a_match_in = head_cmd.is_match;
         a_byte_in  = head_cmd.lit_byte;
         a_src_in   = head_cmd.src;
         a_len_in   = head_cmd.len;
         a_done_in  = head_cmd.done;
      end else if (issue) begin
         a_busy_in = !a_final;
         a_src_in  = a_src_ff + 1'b1;
         a_len_in  = a_len_ff - 1'b1;
      end
   end

   always_comb begin
      b_v_in       = advance ? issue : b_v_ff;
      rsp_valid_in = advance ? b_v_ff : rsp_valid_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      if (load && head_cmd.start) begin
         wp_in   = WinAddrW'(1);
         fill_in = '0;
      end else if (advance && b_v_ff) begin
         wp_in   = wp_ff + 1'b1;
         fill_in = fill_ff[WinAddrW] ? fill_ff : fill_ff + 1'b1;
      end
   end

   // Window memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (advance) begin
         mem_q_ff <= window_mem_ff[a_src_ff];
         if (b_v_ff) begin
            window_mem_ff[wp_ff] <= b_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         b_match_ff <= a_match_ff;
         b_byte_ff  <= a_byte_ff;
         b_fwd_ff   <= b_v_ff && (a_src_ff == wp_ff);
         b_hit_ff   <= entry_valid;
         b_last_ff  <= a_final;
         b_done_ff  <= a_final && a_done_ff;
      end
      if (advance && b_v_ff) begin
         last_wr_ff  <= b_data;
         rsp_byte_ff <= b_data;
         rsp_last_ff <= b_last_ff;
         rsp_done_ff <= b_done_ff;
      end
      a_match_ff <= a_match_in;
      a_byte_ff  <= a_byte_in;
      a_src_ff   <= a_src_in;
      a_len_ff   <= a_len_in;
      a_done_ff  <= a_done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_busy_ff    <= 1'b0;
         b_v_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wp_ff        <= WinAddrW'(1);
         fill_ff      <= '0;
      end else begin
         a_busy_ff    <= a_busy_in;
         b_v_ff       <= b_v_in;
         rsp_valid_ff <= rsp_valid_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_stream_done = rsp_done_ff;

endmodule

// ===== src/lzss_stream_decompressor_unit.sv =====
// Top level of the LZSS stream decompressor with a 4096-byte window.
// The block takes one compressed byte per word on the req_ channel and
// returns decompressed bytes on the rsp_ channel. A control byte or the high
// byte of a match is consumed by the parser and returns nothing; a literal
// returns one byte and a match low byte returns up to 17. The copy engine
// emits at most one byte per cycle from the window memory's single read port,
// none while the rsp_ channel is stalled, and each command needs a load step
// of its own before its bytes, so the engine takes a new command only once it
// is through with the last. A four-entry command queue lets the parser run
// ahead of the copy engine, and an output register holds a finished byte while
// the engine prepares the next one. A stream start needs no clearing pass:
// window entries not yet written since the start read as zero by means of a
// fill count, so a start only waits for the engine to drain its read stage,
// longer while the rsp_ channel is stalled. Output stops at the length in the
// csr_ register; later input words are taken and dropped.
`include "lzss_stream_decompressor_unit_assert.svh"

module lzss_stream_decompressor_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_in_byte,
   input  logic                              req_stream_start,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_out_byte,
   output logic                              rsp_last_of_run,
   output logic                              rsp_stream_done,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lzsd_pkg::CountW-1:0]       csr_output_length
);
   import lzsd_pkg::*;

   // Configured output length; the user writes it only while idle; unchecked.
   logic [CountW-1:0]  output_length_ff;

   logic               q_push;
   logic               q_pop;
   cmd_type            q_push_cmd;
   cmd_type            q_head;
   queue_status_type   q_status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         output_length_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         output_length_ff <= csr_output_length;
      end
   end

   // The parser turns each accepted word into at most one copy command.
   lzsd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .req_stream_start (req_stream_start),
      .output_length    (output_length_ff),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_cmd            (q_push_cmd)
   );

   lzsd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .pop      (q_pop),
      .head_cmd (q_head),
      .status   (q_status)
   );

   // The copy engine writes every emitted byte back into the window.
   lzsd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_cmd        (q_head),
      .q_status        (q_status),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_stream_done (rsp_stream_done)
   );

   // The queue must never be written when full or read when empty.
   `LZSD_ASSERT_IMPLIES(a_no_overflow, q_push, !q_status.full)
   `LZSD_ASSERT_IMPLIES(a_no_underflow, q_pop, !q_status.empty)
   // A pushed command is visible to the copy engine in the next cycle.
   `LZSD_ASSERT_NEXT(a_push_seen, q_push && !q_pop, !q_status.empty)
   // The byte that completes a stream always ends the run of its input word.
   `LZSD_ASSERT_IMPLIES(a_done_is_last, rsp_valid && rsp_stream_done, rsp_last_of_run)

endmodule

// ===== bench/lzss_stream_decompressor_unit_test.sv =====
// Self-checking testbench for the LZSS stream decompressor unit.
module lzss_stream_decompressor_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import lzsd_pkg::*;

   // The command queue holds four commands of at most 17 bytes each, so this
   // wait lets any work that yields no byte drain out before the length
   // register is rewritten or the run ends.
   localparam int DRAIN_CYCLES = 100;
   // About 130 words, each with up to 17 bytes under random stalls, plus a
   // hold-off per register write, stay far below this limit.
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_WORDS = 90;

   // One decompressed byte as it should leave the rsp_ channel.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       done;
   } out_word_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [7:0]          req_in_byte;
   logic                req_stream_start;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [7:0]          rsp_out_byte;
   logic                rsp_last_of_run;
   logic                rsp_stream_done;
   logic                csr_valid;
   logic                csr_ready;
   logic [CountW-1:0]   csr_output_length;

   // Our own copy of the decoder state, advanced once per accepted word.
   logic [7:0]          window_copy [WinDepth];
   logic [WinAddrW-1:0] next_write;
   logic [7:0]          flag_shift;
   logic [3:0]          flags_remaining;
   phase_type           parse_phase;
   logic [7:0]          match_high;
   logic [CountW-1:0]   bytes_made;
   logic [CountW-1:0]   length_setting;

   out_word_type        pending_bytes [$];
   int                  error_count = 0;
   int                  cycle_count = 0;
   int                  taken_words = 0;
   bit                  steady_flow;

   lzss_stream_decompressor_unit uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_stream_start  (req_stream_start),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_stream_done   (rsp_stream_done),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_output_length (csr_output_length)
   );

   always #10 clock = ~clock;

   // The run is abandoned if it goes on far longer than any correct run could.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // The receiver stalls at random with a chance of 13 percent, except during the
   // steady stretch of the random test, when it takes every byte at once.
   always @(negedge clock) begin
      rsp_ready <= steady_flow || ($urandom_range(99) >= 13);
   end

   // Every byte taken from the rsp_ channel is matched against the oldest
   // byte still owed by the prediction.
   always @(posedge clock) begin : check_output
      out_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_bytes.size() == 0) begin
            $error("out_byte: expected nothing, got %02h", rsp_out_byte);
            error_count++;
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_out_byte !== want.data) begin
               $error("out_byte: expected %02h, got %02h", want.data, rsp_out_byte);
               error_count++;
            end
            if (rsp_last_of_run !== want.last) begin
               $error("last_of_run: expected %0b, got %0b", want.last, rsp_last_of_run);
               error_count++;
            end
            if (rsp_stream_done !== want.done) begin
               $error("stream_done: expected %0b, got %0b", want.done, rsp_stream_done);
               error_count++;
            end
         end
      end
   end

   // A stream start clears the window and the parser, but not the length.
   function automatic void restart_stream();
      foreach (window_copy[i]) window_copy[i] = 8'h00;
      next_write      = 12'd1;
      flag_shift      = 8'h00;
      flags_remaining = 4'd0;
      parse_phase     = PHASE_CONTROL;
      match_high      = 8'h00;
      bytes_made      = '0;
   endfunction

   // Each produced byte goes into the window as well as out of the block.
   function automatic void emit_byte(input logic [7:0] value);
      out_word_type owed;
      window_copy[next_write] = value;
      next_write = next_write + 1'b1;
      bytes_made = bytes_made + 1'b1;
      owed.data  = value;
      owed.last  = 1'b0;
      owed.done  = (bytes_made == length_setting);
      pending_bytes.insert(pending_bytes.size(), owed);
   endfunction

   // Once all eight flags of a control byte are used, the next word is control.
   function automatic void use_flag();
      flag_shift = flag_shift >> 1;
      if (flags_remaining != 0) flags_remaining = flags_remaining - 1'b1;
      parse_phase = (flags_remaining != 0) ? PHASE_FIRST : PHASE_CONTROL;
   endfunction

   // Works out the bytes that one accepted compressed word must produce.
   function automatic void decode_word(input logic [7:0] value, input logic start);
      logic [WinAddrW-1:0] src;
      logic [4:0]          remaining;
      int                  first_new;
      if (start) restart_stream();
      first_new = pending_bytes.size();
      if (bytes_made >= length_setting) return;
      taken_words++;
      case (parse_phase)
         PHASE_FIRST: begin
            if (flag_shift[0]) begin
               emit_byte(value);
               use_flag();
            end else begin
               match_high  = value;
               parse_phase = PHASE_SECOND;
            end
         end
         PHASE_SECOND: begin
            // The copy reads the window one byte at a time, so a source that
            // overlaps the destination repeats the bytes just written.
            src       = {match_high, value[7:4]};
            remaining = {1'b0, value[3:0]} + MatchLenBias;
            while (remaining != 0 && bytes_made < length_setting) begin
               emit_byte(window_copy[src]);
               src       = src + 1'b1;
               remaining = remaining - 1'b1;
            end
            use_flag();
         end
         default: begin
            flag_shift      = value;
            flags_remaining = FlagsPerControl;
            parse_phase     = PHASE_FIRST;
         end
      endcase
      if (pending_bytes.size() > first_new) pending_bytes[pending_bytes.size() - 1].last = 1'b1;
   endfunction

   // Offers one compressed word, called and left at a falling edge. The
   // sender may hold back at random first, unless the flow is steady.
   task automatic send_word(input logic [7:0] value, input logic start);
      while (!steady_flow && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_in_byte      <= value;
      req_stream_start <= start;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      decode_word(value, start);
   endtask

   // The length register is only rewritten once the block has gone quiet.
   task automatic set_output_length(input logic [CountW-1:0] value);
      req_valid <= 1'b0;
      while (pending_bytes.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_valid         <= 1'b1;
      csr_output_length <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      length_setting = value;
      csr_valid <= 1'b0;
   endtask

   // With a length of zero every word is taken and dropped.
   task automatic test_zero_length();
      set_output_length('0);
      send_word(8'h00, 1'b1);
      send_word(8'hFF, 1'b1);
   endtask

   // Control byte 0xF5 gives literal, match, literal, match, then four literals.
   // The first match overlaps its own output and repeats 0xFF seventeen times;
   // the second reads the last window entry and wraps round to entry zero.
   task automatic test_literals_and_matches();
      set_output_length(24'd40);
      send_word(8'hF5, 1'b1);
      send_word(8'hFF, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'h1F, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'hF0, 1'b0);
      send_word(8'h80, 1'b0);
      send_word(8'h01, 1'b0);
      send_word(8'h7F, 1'b0);
      send_word(8'hAA, 1'b0);
   endtask

   // Lowering the length below the count mutes the stream; raising it again
   // resumes decoding, and a long match is then cut off at the new length.
   task automatic test_length_changes();
      set_output_length(24'd20);
      send_word(8'h00, 1'b0);
      set_output_length(24'd30);
      send_word(8'h00, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'h2F, 1'b0);
      send_word(8'h11, 1'b0);
   endtask

   // A match left half-finished yields nothing, and a fresh start discards it.
   task automatic test_incomplete_token();
      set_output_length(24'd100);
      send_word(8'h00, 1'b1);
      send_word(8'h12, 1'b0);
      send_word(8'h01, 1'b1);
      send_word(8'hAA, 1'b0);
   endtask

   task automatic test_full_length();
      set_output_length({CountW{1'b1}});
      send_word(8'hFF, 1'b1);
      send_word(8'h5A, 1'b0);
   endtask

   // One stream of mostly well-formed tokens with random content. Matches
   // point either just behind the write position or anywhere in the window.
   // Now and then a stray word is slipped in or the stream breaks off.
   task automatic run_random_stream();
      logic [7:0]          ctrl;
      logic [WinAddrW-1:0] src;
      logic [WinAddrW-1:0] back;
      logic [3:0]          nibble;
      int                  groups;
      bit                  first;
      bit                  quit;
      case ($urandom_range(9))
         0:       set_output_length(CountW'($urandom_range(1, 24)));
         1:       set_output_length(CountW'($urandom));
         default: set_output_length(CountW'($urandom_range(16, 220)));
      endcase
      first  = ($urandom_range(9) != 0);
      groups = $urandom_range(1, 4);
      quit   = 1'b0;
      for (int g = 0; g < groups && !quit; g++) begin
         ctrl = 8'($urandom);
         send_word(ctrl, first);
         first = 1'b0;
         for (int k = 0; k < 8 && !quit; k++) begin
            if ($urandom_range(99) < 4) send_word(8'($urandom), $urandom_range(3) == 0);
            if ($urandom_range(99) < 3) begin
               // The stream ends here, possibly with only the high byte sent.
               if (!ctrl[k]) send_word(8'($urandom), 1'b0);
               quit = 1'b1;
            end else if (ctrl[k]) begin
               send_word(8'($urandom), 1'b0);
            end else begin
               if ($urandom_range(1) == 0) begin
                  back = WinAddrW'($urandom_range(1, 40));
                  src  = next_write - back;
               end else begin
                  src = WinAddrW'($urandom);
               end
               nibble = 4'($urandom);
               send_word(src[11:4], 1'b0);
               send_word({src[3:0], nibble}, 1'b0);
            end
            // Past the length one stray word shows that it is dropped.
            if (!quit && bytes_made >= length_setting) begin
               send_word(8'($urandom), 1'b0);
               quit = 1'b1;
            end
         end
      end
   endtask

   // Random streams until enough words have really been decoded; the first
   // two streams run without any idling on either side.
   task automatic test_random_streams();
      int start_count;
      int stream_no;
      start_count = taken_words;
      stream_no   = 0;
      while (taken_words - start_count < RANDOM_WORDS) begin
         steady_flow <= (stream_no == 0 || stream_no == 1);
         run_random_stream();
         stream_no++;
      end
      steady_flow <= 1'b0;
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_in_byte       = 8'h00;
      req_stream_start  = 1'b0;
      rsp_ready         = 1'b0;
      csr_valid         = 1'b0;
      csr_output_length = '0;
      steady_flow       = 1'b0;
      restart_stream();
      length_setting = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_zero_length();
      test_literals_and_matches();
      test_length_changes();
      test_incomplete_token();
      test_full_length();
      test_random_streams();

      // Let every owed byte arrive, then watch a while for stray ones.
      req_valid <= 1'b0;
      while (pending_bytes.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0 && pending_bytes.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
